@@ sv/clb_pkg.sv @@
// ----------------------------------------------------------------------------
// Cell list binning package
// Shared codes, widths, reset values and the controller to datapath bundles.
// ----------------------------------------------------------------------------
package clb_pkg;

  localparam int CMD_W    = 2;
  localparam int ID_W     = 16;
  localparam int POS_W    = 32;
  localparam int INV_W    = 32;
  localparam int NCELL_W  = 5;
  localparam int CAP_W    = 6;
  localparam int FACT_W   = 8;
  localparam int CNT_W    = 16;
  localparam int OIDX_W   = 4;
  localparam int CFG_IX_W = 3;
  localparam int CFG_D_W  = 32;
  localparam int QCOORD_W = 24;
  localparam int FRAC_SH  = 40;

  localparam int MAX_PARTICLES  = 65536;
  localparam int MIN_POPULATION = 32;

  localparam logic [INV_W-1:0]   INV_LEN_RST = 32'd16777216;
  localparam logic [NCELL_W-1:0] CELLS_RST   = 5'd16;
  localparam logic [CAP_W-1:0]   CAP_RST     = 6'd32;
  localparam logic [FACT_W-1:0]  FACTOR_RST  = 8'd19;

  typedef enum logic [CMD_W-1:0] {
    CMD_BIN    = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_FINISH = 2'd2
  } clb_cmd_e;

  typedef enum logic [CFG_IX_W-1:0] {
    REG_INV_LEN_X   = 3'd0,
    REG_INV_LEN_Y   = 3'd1,
    REG_INV_LEN_Z   = 3'd2,
    REG_CELLS_X     = 3'd3,
    REG_CELLS_Y     = 3'd4,
    REG_CELLS_Z     = 3'd5,
    REG_SLOT_CAP    = 3'd6,
    REG_SAFETY_FACT = 3'd7
  } clb_reg_e;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic idx_en;
    logic addr_en;
    logic clr_en;
    logic bin_commit;
    logic clr_commit;
    logic fin_mul_en;
    logic fin_commit;
  } clb_ctl_t;

  typedef struct packed {
    logic out_free;
    logic clr_last;
  } clb_sts_t;

endpackage

@@ sv/clb_ifs.sv @@
// ----------------------------------------------------------------------------
// Cell list binning channels
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface clb_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] particle_id;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;

  modport source (output valid, cmd, particle_id, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, cmd, particle_id, pos_x, pos_y, pos_z, output ready);
endinterface

interface clb_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cell_ix;
  logic [3:0]  cell_iy;
  logic [3:0]  cell_iz;
  logic [15:0] slot_index;
  logic        outside_grid;
  logic        slot_overflow;
  logic [15:0] max_occupancy;
  logic        grow_request;
  logic [15:0] new_capacity;

  modport source (output valid, cell_ix, cell_iy, cell_iz, slot_index, outside_grid,
                  slot_overflow, max_occupancy, grow_request, new_capacity,
                  input ready);
  modport sink   (input valid, cell_ix, cell_iy, cell_iz, slot_index, outside_grid,
                  slot_overflow, max_occupancy, grow_request, new_capacity,
                  output ready);
endinterface

interface clb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/cell_list_binning_core.sv @@
// ----------------------------------------------------------------------------
// Cell list binning core
// Bins particles into a grid of cells and reports occupancy and growth needs.
// ----------------------------------------------------------------------------
// Usage: items arrive on item_i with a command. A bin item computes the cell
// of a Q16.16 position from the Q8.24 inverse cell lengths, appends the id to
// that cell's slot list and returns one result with the cell, slot and flags.
// A clear item zeroes every cell count; a finish item reports the largest
// occupancy and a suggested capacity. Command code 3 is taken and dropped.
// Registers are to be written on cfg_i only while the core is idle; the core
// does not enforce this, and cfg_i is always ready.
// A bin item is loaded, multiplied, indexed, turned into a cell address,
// and its count is read, incremented and written back with its result; the
// core takes no new item until that item's result has been committed.
// A finish item multiplies and then reports; a clear item walks the count
// memory one cell per cycle over all CELLS_PER_DIM cubed cells.
// After reset the same walk runs once over all cells (4096 by default)
// before the first item is taken. Results sit in an output register;
// a stalled receiver holds the result and the core stops before its next one.
// ----------------------------------------------------------------------------
module cell_list_binning_core #(
  parameter int CELLS_PER_DIM  = 16,
  parameter int SLOTS_PER_CELL = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  clb_item_if.sink      item_i,
  clb_result_if.source  result_o,
  clb_cfg_if.sink       cfg_i
);
  import clb_pkg::*;

  clb_ctl_t ctl;
  clb_sts_t sts;

  assign cfg_i.ready = 1'b1;

  clb_ctrl u_clb_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_cmd_i   (item_i.cmd),
    .sts_i      (sts),
    .in_ready_o (item_i.ready),
    .ctl_o      (ctl)
  );

  clb_datapath #(
    .CELLS_PER_DIM  (CELLS_PER_DIM),
    .SLOTS_PER_CELL (SLOTS_PER_CELL)
  ) u_clb_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .particle_id_i   (item_i.particle_id),
    .pos_x_i         (item_i.pos_x),
    .pos_y_i         (item_i.pos_y),
    .pos_z_i         (item_i.pos_z),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .out_ready_i     (result_o.ready),
    .out_valid_o     (result_o.valid),
    .cell_ix_o       (result_o.cell_ix),
    .cell_iy_o       (result_o.cell_iy),
    .cell_iz_o       (result_o.cell_iz),
    .slot_index_o    (result_o.slot_index),
    .outside_grid_o  (result_o.outside_grid),
    .slot_overflow_o (result_o.slot_overflow),
    .max_occupancy_o (result_o.max_occupancy),
    .grow_request_o  (result_o.grow_request),
    .new_capacity_o  (result_o.new_capacity)
  );

endmodule

@@ sv/clb_ctrl.sv @@
// ----------------------------------------------------------------------------
// Cell list binning controller
// Sequences the bin, clear and finish operations and the reset sweep.
// ----------------------------------------------------------------------------
module clb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_cmd_i,
  input  clb_pkg::clb_sts_t   sts_i,
  output logic                in_ready_o,
  output clb_pkg::clb_ctl_t   ctl_o
);
  import clb_pkg::*;

  typedef enum logic [10:0] {
    S_INIT  = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_MUL   = 11'b000_0000_0100,
    S_IDX   = 11'b000_0000_1000,
    S_ADDR  = 11'b000_0001_0000,
    S_READ  = 11'b000_0010_0000,
    S_UPD   = 11'b000_0100_0000,
    S_CLEAR = 11'b000_1000_0000,
    S_CDONE = 11'b001_0000_0000,
    S_FMUL  = 11'b010_0000_0000,
    S_FOUT  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_INIT: begin
        ctl_o.clr_en = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_cmd_i)
            CMD_BIN: begin
              ctl_o.load = 1'b1;
              state_d    = S_MUL;
            end
            CMD_CLEAR:  state_d = S_CLEAR;
            CMD_FINISH: state_d = S_FMUL;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_MUL: begin
        ctl_o.mul_en = 1'b1;
        state_d      = S_IDX;
      end
      S_IDX: begin
        ctl_o.idx_en = 1'b1;
        state_d      = S_ADDR;
      end
      S_ADDR: begin
        ctl_o.addr_en = 1'b1;
        state_d       = S_READ;
      end
      S_READ: state_d = S_UPD;
      S_UPD: begin
        if (sts_i.out_free) begin
          ctl_o.bin_commit = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_CLEAR: begin
        ctl_o.clr_en = 1'b1;
        if (sts_i.clr_last) state_d = S_CDONE;
      end
      S_CDONE: begin
        if (sts_i.out_free) begin
          ctl_o.clr_commit = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_FMUL: begin
        ctl_o.fin_mul_en = 1'b1;
        state_d          = S_FOUT;
      end
      S_FOUT: begin
        if (sts_i.out_free) begin
          ctl_o.fin_commit = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/clb_datapath.sv @@
// ----------------------------------------------------------------------------
// Cell list binning datapath
// Registers, coordinate multipliers, count and member memories, result stage.
// ----------------------------------------------------------------------------
module clb_datapath #(
  parameter int CELLS_PER_DIM  = 16,
  parameter int SLOTS_PER_CELL = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [clb_pkg::CFG_IX_W-1:0] cfg_index_i,
  input  logic [clb_pkg::CFG_D_W-1:0]  cfg_data_i,
  input  logic [clb_pkg::ID_W-1:0]     particle_id_i,
  input  logic [clb_pkg::POS_W-1:0]    pos_x_i,
  input  logic [clb_pkg::POS_W-1:0]    pos_y_i,
  input  logic [clb_pkg::POS_W-1:0]    pos_z_i,
  input  clb_pkg::clb_ctl_t            ctl_i,
  output clb_pkg::clb_sts_t            sts_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [clb_pkg::OIDX_W-1:0]   cell_ix_o,
  output logic [clb_pkg::OIDX_W-1:0]   cell_iy_o,
  output logic [clb_pkg::OIDX_W-1:0]   cell_iz_o,
  output logic [clb_pkg::CNT_W-1:0]    slot_index_o,
  output logic                         outside_grid_o,
  output logic                         slot_overflow_o,
  output logic [clb_pkg::CNT_W-1:0]    max_occupancy_o,
  output logic                         grow_request_o,
  output logic [clb_pkg::CNT_W-1:0]    new_capacity_o
);
  import clb_pkg::*;

  localparam int NUM_CELLS   = CELLS_PER_DIM * CELLS_PER_DIM * CELLS_PER_DIM;
  localparam int NUM_MEMBERS = NUM_CELLS * SLOTS_PER_CELL;
  localparam int IW  = (CELLS_PER_DIM > 1) ? $clog2(CELLS_PER_DIM) : 1;
  localparam int CAW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int MAW = (NUM_MEMBERS > 1) ? $clog2(NUM_MEMBERS) : 1;
  localparam int SW  = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
  localparam int NW  = 8;
  localparam int CEW = 9;
  localparam int MFW = CNT_W + FACT_W;
  localparam int CFW = CEW + FACT_W;
  localparam int SGW = MFW - 4;

  logic [INV_W-1:0]   inv_q [3];
  logic [NCELL_W-1:0] cells_q [3];
  logic [CAP_W-1:0]   cap_q;
  logic [FACT_W-1:0]  factor_q;

  logic [POS_W-1:0]    pos_q [3];
  logic [ID_W-1:0]     id_q;
  logic [QCOORD_W-1:0] coord_q [3];
  logic [IW-1:0]       idx_q [3];
  logic                outside_q;
  logic [CAW-1:0]      addr_q;
  logic [CAW-1:0]      clr_q;
  logic [CNT_W-1:0]    cnt_rd_q;
  logic [CNT_W-1:0]    max_q;
  logic [MFW-1:0]      mf_q;
  logic [CFW-1:0]      capf_q;

  logic [CNT_W-1:0] count_mem [NUM_CELLS];
  logic [ID_W-1:0]  member_mem [NUM_MEMBERS];

  logic             out_valid_q;
  logic [OIDX_W-1:0] ix_q, iy_q, iz_q;
  logic [CNT_W-1:0] slot_q, maxo_q, newcap_q;
  logic             outg_q, ovf_q, grow_q;

  logic [CEW-1:0]   cap_eff;
  logic [NW-1:0]    n_eff [3];
  logic [2:0]       clamp;
  logic             overflow;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] max_next;
  logic             cnt_we;
  logic [CAW-1:0]   cnt_wa;
  logic [CNT_W-1:0] cnt_wd;
  logic [MAW-1:0]   mem_wa;
  logic [SGW-1:0]   sug;
  logic [CNT_W-1:0] sug_sat;
  logic             grow;

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CEW'(1);
    end else if (CEW'(cap_q) > CEW'(SLOTS_PER_CELL)) begin
      cap_eff = CEW'(SLOTS_PER_CELL);
    end else begin
      cap_eff = CEW'(cap_q);
    end
    for (int d = 0; d < 3; d++) begin
      if (cells_q[d] == '0) begin
        n_eff[d] = NW'(1);
      end else if (NW'(cells_q[d]) > NW'(CELLS_PER_DIM)) begin
        n_eff[d] = NW'(CELLS_PER_DIM);
      end else begin
        n_eff[d] = NW'(cells_q[d]);
      end
      clamp[d] = coord_q[d] >= QCOORD_W'(n_eff[d]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < 3; d++) begin
        inv_q[d]   <= INV_LEN_RST;
        cells_q[d] <= CELLS_RST;
      end
      cap_q    <= CAP_RST;
      factor_q <= FACTOR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_INV_LEN_X:   inv_q[0]   <= cfg_data_i[INV_W-1:0];
        REG_INV_LEN_Y:   inv_q[1]   <= cfg_data_i[INV_W-1:0];
        REG_INV_LEN_Z:   inv_q[2]   <= cfg_data_i[INV_W-1:0];
        REG_CELLS_X:     cells_q[0] <= cfg_data_i[NCELL_W-1:0];
        REG_CELLS_Y:     cells_q[1] <= cfg_data_i[NCELL_W-1:0];
        REG_CELLS_Z:     cells_q[2] <= cfg_data_i[NCELL_W-1:0];
        REG_SLOT_CAP:    cap_q      <= cfg_data_i[CAP_W-1:0];
        REG_SAFETY_FACT: factor_q   <= cfg_data_i[FACT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      pos_q[0] <= pos_x_i;
      pos_q[1] <= pos_y_i;
      pos_q[2] <= pos_z_i;
      id_q     <= particle_id_i;
    end
    if (ctl_i.mul_en) begin
      for (int d = 0; d < 3; d++) begin
        coord_q[d] <= QCOORD_W'(((2*POS_W)'(pos_q[d]) * (2*POS_W)'(inv_q[d])) >> FRAC_SH);
      end
    end
    if (ctl_i.idx_en) begin
      outside_q <= |clamp;
      for (int d = 0; d < 3; d++) begin
        if (clamp[d]) begin
          idx_q[d] <= IW'(n_eff[d] - NW'(1));
        end else begin
          idx_q[d] <= IW'(coord_q[d]);
        end
      end
    end
    if (ctl_i.addr_en) begin
      addr_q <= CAW'((int'(idx_q[0]) * CELLS_PER_DIM + int'(idx_q[1])) * CELLS_PER_DIM
                     + int'(idx_q[2]));
    end
    if (ctl_i.fin_mul_en) begin
      mf_q   <= MFW'(max_q) * MFW'(factor_q);
      capf_q <= CFW'(cap_eff) * CFW'(factor_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctl_i.clr_en) begin
      clr_q <= sts_o.clr_last ? '0 : clr_q + CAW'(1);
    end
  end

  assign overflow = cnt_rd_q >= CNT_W'(cap_eff);
  assign cnt_inc  = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + CNT_W'(1);
  assign max_next = (cnt_inc > max_q) ? cnt_inc : max_q;
  assign cnt_we   = ctl_i.clr_en | ctl_i.bin_commit;
  assign cnt_wa   = ctl_i.clr_en ? clr_q : addr_q;
  assign cnt_wd   = ctl_i.clr_en ? '0 : cnt_inc;
  assign mem_wa   = MAW'(int'(addr_q) * SLOTS_PER_CELL + int'(cnt_rd_q[SW-1:0]));

  always_ff @(posedge clk_i) begin
    if (cnt_we) count_mem[cnt_wa] <= cnt_wd;
    cnt_rd_q <= count_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.bin_commit && !overflow) begin
      member_mem[mem_wa] <= ID_W'(32'(id_q) % MAX_PARTICLES);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
    end else if (ctl_i.bin_commit) begin
      max_q <= max_next;
    end else if (ctl_i.clr_commit) begin
      max_q <= '0;
    end
  end

  assign grow    = {max_q, 4'b0000} >= (CNT_W+4)'(capf_q);
  assign sug     = mf_q[MFW-1:4];
  always_comb begin
    if (sug < SGW'(MIN_POPULATION)) begin
      sug_sat = CNT_W'(MIN_POPULATION);
    end else if (sug > SGW'(16'hFFFF)) begin
      sug_sat = '1;
    end else begin
      sug_sat = CNT_W'(sug);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.bin_commit) begin
      ix_q     <= OIDX_W'(idx_q[0]);
      iy_q     <= OIDX_W'(idx_q[1]);
      iz_q     <= OIDX_W'(idx_q[2]);
      slot_q   <= cnt_rd_q;
      outg_q   <= outside_q;
      ovf_q    <= overflow;
      maxo_q   <= max_next;
      grow_q   <= 1'b0;
      newcap_q <= '0;
    end else if (ctl_i.clr_commit || ctl_i.fin_commit) begin
      ix_q     <= '0;
      iy_q     <= '0;
      iz_q     <= '0;
      slot_q   <= '0;
      outg_q   <= 1'b0;
      ovf_q    <= 1'b0;
      maxo_q   <= ctl_i.fin_commit ? max_q : '0;
      grow_q   <= ctl_i.fin_commit & grow;
      newcap_q <= (ctl_i.fin_commit && grow) ? sug_sat : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.bin_commit || ctl_i.clr_commit || ctl_i.fin_commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.clr_last = clr_q == CAW'(NUM_CELLS - 1);

  assign out_valid_o     = out_valid_q;
  assign cell_ix_o       = ix_q;
  assign cell_iy_o       = iy_q;
  assign cell_iz_o       = iz_q;
  assign slot_index_o    = slot_q;
  assign outside_grid_o  = outg_q;
  assign slot_overflow_o = ovf_q;
  assign max_occupancy_o = maxo_q;
  assign grow_request_o  = grow_q;
  assign new_capacity_o  = newcap_q;

endmodule

@@ sv/clb_checker.sv @@
// ----------------------------------------------------------------------------
// Cell list binning checker
// Port-level properties of the result channel, bound to the core.
// ----------------------------------------------------------------------------
module clb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] slot_index_i,
  input logic        slot_overflow_i,
  input logic [15:0] max_occupancy_i,
  input logic        grow_request_i,
  input logic [15:0] new_capacity_i
);
  import clb_pkg::*;

  // A stalled result stays offered with its slot index, maximum occupancy and suggested capacity unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(max_occupancy_i)
      && $stable(new_capacity_i) && $stable(slot_index_i))
    else $error("result changed while stalled");

  a_grow_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && grow_request_i |-> new_capacity_i >= 16'(MIN_POPULATION))
    else $error("suggested capacity below the minimum");

  a_no_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !grow_request_i |-> new_capacity_i == '0)
    else $error("capacity suggested without a grow request");

  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && slot_overflow_i |-> slot_index_i != '0 && !grow_request_i
      && max_occupancy_i >= slot_index_i)
    else $error("overflow reported on an empty cell");

endmodule

bind cell_list_binning_core clb_checker u_clb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .slot_index_i    (result_o.slot_index),
  .slot_overflow_i (result_o.slot_overflow),
  .max_occupancy_i (result_o.max_occupancy),
  .grow_request_i  (result_o.grow_request),
  .new_capacity_i  (result_o.new_capacity)
);

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// Cell list binning core testbench
// Streams bin, clear and finish items through the core under several grid,
// capacity and headroom settings and checks every result item against a
// cycle-free prediction of the cell counts, running maximum and growth hint.
// Both channels idle at random, and the receiver holds off once for a long
// stretch. A closing burst drives one cell past its slot capacity.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import clb_pkg::*;

  localparam int GRID_DIM        = 16;
  localparam int GRID_CELLS      = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int SLOTS           = 32;
  localparam int IDLE_LIMIT      = 20000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AFTER  = 200;
  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_ITEMS     = 75;
  localparam int CALM_PHASE      = 5;
  localparam int SATURATE_BINS   = 40;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
  } particle_item_t;

  typedef struct packed {
    logic [OIDX_W-1:0] ix;
    logic [OIDX_W-1:0] iy;
    logic [OIDX_W-1:0] iz;
    logic [CNT_W-1:0]  slot;
    logic              outside;
    logic              overflow;
    logic [CNT_W-1:0]  peak;
    logic              grow;
    logic [CNT_W-1:0]  capacity;
  } bin_report_t;

  logic clk_i;
  logic rst_ni;

  clb_item_if   item_bus ();
  clb_result_if result_bus ();
  clb_cfg_if    cfg_bus ();

  cell_list_binning_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  logic [INV_W-1:0]   inv_len_q [3];
  logic [NCELL_W-1:0] cells_q [3];
  logic [CAP_W-1:0]   slot_cap_q;
  logic [FACT_W-1:0]  factor_q;
  logic [CNT_W-1:0]   occupancy [GRID_CELLS];
  logic [CNT_W-1:0]   peak_occupancy;

  particle_item_t particle_feed [$];
  bin_report_t    awaited_reports [$];

  int  items_queued = 0;
  int  items_taken  = 0;
  int  mismatches   = 0;
  int  feed_gap     = 0;
  int  drain_stall  = 0;
  int  quiet_cycles = 0;
  logic calm;
  logic starve;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return '0;
      2: return '1;
      default: return $urandom_range(0, 32'h0012_0000);
    endcase
  endfunction

  // Returns the clamp flag above the four index bits.
  function automatic logic [4:0] axis_cell(logic [POS_W-1:0] pos, logic [INV_W-1:0] inv,
                                           logic [NCELL_W-1:0] ncells);
    logic [63:0] prod;
    logic [4:0]  lim;
    lim = (ncells == 0) ? 5'd1 : (ncells > GRID_DIM) ? 5'(GRID_DIM) : ncells;
    prod = {32'd0, pos} * {32'd0, inv};
    if ((prod >> FRAC_SH) >= 64'(lim)) return {1'b1, 4'(lim - 5'd1)};
    return {1'b0, prod[43:40]};
  endfunction

  function automatic bin_report_t bin_and_tally(particle_item_t it);
    bin_report_t r;
    logic [4:0]  ax, ay, az;
    logic [11:0] cell_addr;
    logic [CNT_W-1:0] before_cnt;
    int unsigned cap, demand, suggest;
    r = '0;
    cap = (slot_cap_q == 0) ? 1 : (slot_cap_q > SLOTS) ? SLOTS : slot_cap_q;
    case (it.cmd)
      CMD_BIN: begin
        ax = axis_cell(it.x, inv_len_q[0], cells_q[0]);
        ay = axis_cell(it.y, inv_len_q[1], cells_q[1]);
        az = axis_cell(it.z, inv_len_q[2], cells_q[2]);
        cell_addr = {ax[3:0], ay[3:0], az[3:0]};
        before_cnt = occupancy[cell_addr];
        if (before_cnt != 16'hFFFF) occupancy[cell_addr] = before_cnt + 16'd1;
        if (occupancy[cell_addr] > peak_occupancy) peak_occupancy = occupancy[cell_addr];
        r.ix       = ax[3:0];
        r.iy       = ay[3:0];
        r.iz       = az[3:0];
        r.slot     = before_cnt;
        r.outside  = ax[4] | ay[4] | az[4];
        r.overflow = (before_cnt >= cap);
        r.peak     = peak_occupancy;
      end
      CMD_CLEAR: begin
        foreach (occupancy[c]) occupancy[c] = '0;
        peak_occupancy = '0;
      end
      CMD_FINISH: begin
        r.peak = peak_occupancy;
        demand = peak_occupancy * factor_q;
        if (peak_occupancy * 16 >= cap * factor_q) begin
          suggest = demand >> 4;
          if (suggest < MIN_POPULATION) suggest = MIN_POPULATION;
          if (suggest > 32'hFFFF) suggest = 32'hFFFF;
          r.grow     = 1'b1;
          r.capacity = suggest[CNT_W-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                      logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : feed_driver
    particle_item_t taken;
    particle_item_t next_item;
    if (!rst_ni) begin
      item_bus.valid <= 1'b0;
    end else if (!item_bus.valid || item_bus.ready) begin
      if (item_bus.valid) begin
        taken.cmd = item_bus.cmd;
        taken.id  = item_bus.particle_id;
        taken.x   = item_bus.pos_x;
        taken.y   = item_bus.pos_y;
        taken.z   = item_bus.pos_z;
        if (taken.cmd != CMD_UNUSED) awaited_reports.push_back(bin_and_tally(taken));
        items_taken++;
      end
      if (feed_gap != 0) begin
        feed_gap <= feed_gap - 1;
        item_bus.valid <= 1'b0;
      end else if (particle_feed.size() != 0) begin
        next_item = particle_feed.pop_front();
        item_bus.valid       <= 1'b1;
        item_bus.cmd         <= next_item.cmd;
        item_bus.particle_id <= next_item.id;
        item_bus.pos_x       <= next_item.x;
        item_bus.pos_y       <= next_item.y;
        item_bus.pos_z       <= next_item.z;
        feed_gap <= (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
      end else begin
        item_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : report_checker
    bin_report_t want;
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (awaited_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, got cell %0d/%0d/%0d slot %0d",
                   $time, result_bus.cell_ix, result_bus.cell_iy, result_bus.cell_iz,
                   result_bus.slot_index);
          mismatches++;
        end else begin
          want = awaited_reports.pop_front();
          check_field("cell_ix", CNT_W'(want.ix), CNT_W'(result_bus.cell_ix));
          check_field("cell_iy", CNT_W'(want.iy), CNT_W'(result_bus.cell_iy));
          check_field("cell_iz", CNT_W'(want.iz), CNT_W'(result_bus.cell_iz));
          check_field("slot_index", want.slot, result_bus.slot_index);
          check_field("outside_grid", CNT_W'(want.outside), CNT_W'(result_bus.outside_grid));
          check_field("slot_overflow", CNT_W'(want.overflow),
                      CNT_W'(result_bus.slot_overflow));
          check_field("max_occupancy", want.peak, result_bus.max_occupancy);
          check_field("grow_request", CNT_W'(want.grow), CNT_W'(result_bus.grow_request));
          check_field("new_capacity", want.capacity, result_bus.new_capacity);
        end
      end
      if (starve) begin
        result_bus.ready <= 1'b0;
      end else if (drain_stall != 0) begin
        drain_stall <= drain_stall - 1;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) drain_stall <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin : receiver_hold_off
    starve = 1'b0;
    wait (items_taken >= HOLD_OFF_AFTER);
    @(posedge clk_i);
    starve <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    starve <= 1'b0;
  end

  task automatic queue_item(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                            logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [POS_W-1:0] z);
    particle_feed.push_back('{cmd: cmd, id: id, x: x, y: y, z: z});
    items_queued++;
  endtask

  task automatic settle();
    while (items_taken != items_queued || awaited_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_registers(logic [CFG_D_W-1:0] vals [8]);
    clb_reg_e idx;
    for (int k = 0; k < 8; k++) begin
      idx = clb_reg_e'(k);
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx;
      cfg_bus.data  <= vals[k];
      do @(posedge clk_i); while (!cfg_bus.ready);
      case (idx)
        REG_INV_LEN_X:   inv_len_q[0] = vals[k];
        REG_INV_LEN_Y:   inv_len_q[1] = vals[k];
        REG_INV_LEN_Z:   inv_len_q[2] = vals[k];
        REG_CELLS_X:     cells_q[0]   = vals[k][NCELL_W-1:0];
        REG_CELLS_Y:     cells_q[1]   = vals[k][NCELL_W-1:0];
        REG_CELLS_Z:     cells_q[2]   = vals[k][NCELL_W-1:0];
        REG_SLOT_CAP:    slot_cap_q   = vals[k][CAP_W-1:0];
        REG_SAFETY_FACT: factor_q     = vals[k][FACT_W-1:0];
        default: ;
      endcase
    end
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CFG_D_W-1:0] regs [8];
    logic [CMD_W-1:0]   cmd;
    int r;

    item_bus.valid       = 1'b0;
    item_bus.cmd         = CMD_BIN;
    item_bus.particle_id = '0;
    item_bus.pos_x       = '0;
    item_bus.pos_y       = '0;
    item_bus.pos_z       = '0;
    result_bus.ready     = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = REG_INV_LEN_X;
    cfg_bus.data         = '0;
    calm                 = 1'b0;
    rst_ni               = 1'b0;

    for (int d = 0; d < 3; d++) begin
      inv_len_q[d] = INV_LEN_RST;
      cells_q[d]   = CELLS_RST;
    end
    slot_cap_q = CAP_RST;
    factor_q   = FACTOR_RST;
    foreach (occupancy[c]) occupancy[c] = '0;
    peak_occupancy = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: grid corners, clamping on each axis, the ignored
    // command and a clear followed by an empty report.
    queue_item(CMD_BIN, 16'h0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    queue_item(CMD_BIN, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(CMD_BIN, 16'h1234, 32'h000F_FFFF, 32'h000F_FFFF, 32'h000F_FFFF);
    queue_item(CMD_BIN, 16'h8000, 32'h0010_0000, 32'h0000_FFFF, 32'h0008_0000);
    queue_item(CMD_BIN, 16'h0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    queue_item(CMD_FINISH, 16'h0000, '0, '0, '0);
    queue_item(CMD_UNUSED, 16'h5A5A, $urandom, $urandom, $urandom);
    queue_item(CMD_FINISH, 16'($urandom), $urandom, $urandom, $urandom);
    queue_item(CMD_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(CMD_FINISH, 16'h0000, '0, '0, '0);
    settle();

    // Out-of-range register values, a single slot per cell, no headroom
    // and the rounding boundary of the largest inverse length.
    regs = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0080_0000, 32'd0, 32'd17, 32'd31,
             32'd0, 32'd0};
    program_registers(regs);
    queue_item(CMD_BIN, 16'h0007, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0020_0000);
    queue_item(CMD_BIN, 16'h0008, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0020_0000);
    queue_item(CMD_BIN, 16'h0009, 32'h0000_0000, 32'h0000_0100, 32'h0000_0000);
    queue_item(CMD_BIN, 16'h000A, 32'h0000_0000, 32'h0000_0101, 32'h001F_FFFF);
    queue_item(CMD_FINISH, 16'h0000, '0, '0, '0);
    settle();

    regs = '{32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'd16, 32'd16, 32'd16,
             32'd63, 32'd16};
    program_registers(regs);
    queue_item(CMD_BIN, 16'h0100, 32'h0003_8000, 32'h0003_0000, 32'h0003_FFFF);
    queue_item(CMD_BIN, 16'h0101, 32'h0003_0000, 32'h0003_4000, 32'h0003_0001);
    queue_item(CMD_BIN, 16'h0102, 32'h0003_FFFF, 32'h0003_FFFF, 32'h0003_0000);
    queue_item(CMD_FINISH, 16'h0000, '0, '0, '0);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 9))
          0: regs[k] = 32'h0000_0000;
          1: regs[k] = 32'hFFFF_FFFF;
          2: regs[k] = $urandom;
          3: regs[k] = 32'h0100_0000;
          default: regs[k] = $urandom_range(32'h0040_0000, 32'h0200_0000);
        endcase
        case ($urandom_range(0, 9))
          0: regs[k + 3] = 32'd0;
          1: regs[k + 3] = 32'd16;
          2: regs[k + 3] = $urandom_range(17, 31);
          3: regs[k + 3] = $urandom_range(5, 15);
          default: regs[k + 3] = $urandom_range(1, 4);
        endcase
      end
      case ($urandom_range(0, 9))
        0: regs[6] = 32'd0;
        1: regs[6] = 32'd63;
        2: regs[6] = 32'd32;
        3: regs[6] = $urandom_range(0, 63);
        default: regs[6] = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 9))
        0: regs[7] = 32'd0;
        1: regs[7] = 32'd16;
        2: regs[7] = 32'd255;
        default: regs[7] = $urandom_range(0, 255);
      endcase
      program_registers(regs);
      calm = (p == CALM_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 2) cmd = CMD_CLEAR;
        else if (r < 10) cmd = CMD_FINISH;
        else if (r < 14) cmd = CMD_UNUSED;
        else cmd = CMD_BIN;
        queue_item(cmd, 16'($urandom_range(0, 65535)), pick_pos(), pick_pos(), pick_pos());
      end
      queue_item(CMD_FINISH, 16'($urandom_range(0, 65535)), $urandom, $urandom, $urandom);
      settle();
    end

    // One cell takes every bin until it runs out of slots, and the later
    // bins are reported as overflowing.
    regs = '{$urandom, $urandom, $urandom, 32'd0, 32'd1, 32'd0, 32'd32, 32'd255};
    program_registers(regs);
    calm = 1'b1;
    queue_item(CMD_CLEAR, 16'h0000, '0, '0, '0);
    for (int n = 0; n < SATURATE_BINS; n++) begin
      queue_item(CMD_BIN, 16'($urandom_range(0, 65535)), $urandom, $urandom, $urandom);
    end
    queue_item(CMD_FINISH, 16'h0000, '0, '0, '0);
    queue_item(CMD_CLEAR, 16'h0000, '0, '0, '0);
    settle();

    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/clb_pkg.sv
sv/clb_ifs.sv
sv/clb_ctrl.sv
sv/clb_datapath.sv
sv/cell_list_binning_core.sv
sv/clb_checker.sv
bench/tb_top.sv
